>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the lane change detector
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// types, widths and codes shared by the lane change detector modules
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int OFFSET_WIDTH = 16;
  localparam int CONF_WIDTH   = 11;
  localparam int THR_WIDTH    = 15;
  localparam int MAG_WIDTH    = OFFSET_WIDTH + 1;
  localparam int CMP_WIDTH    = (MAG_WIDTH > THR_WIDTH) ? MAG_WIDTH : THR_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUALITY_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_OFFSET_LIMIT = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_JUMP_WIDTH         = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SETTLE_DELTA       = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ABORT_OFFSET       = 3'd4;

  localparam logic [CONF_WIDTH-1:0] RST_QUALITY_THRESHOLD  = 11'd512;
  localparam logic [THR_WIDTH-1:0]  RST_START_OFFSET_LIMIT = 15'd512;
  localparam logic [THR_WIDTH-1:0]  RST_JUMP_WIDTH         = 15'd1536;
  localparam logic [THR_WIDTH-1:0]  RST_SETTLE_DELTA       = 15'd512;
  localparam logic [THR_WIDTH-1:0]  RST_ABORT_OFFSET       = 15'd1024;

  localparam logic [1:0] PHASE_CODE_NONE  = 2'd0;
  localparam logic [1:0] PHASE_CODE_START = 2'd1;
  localparam logic [1:0] PHASE_CODE_IN    = 2'd2;
  localparam logic [1:0] PHASE_CODE_END   = 2'd3;

  localparam logic [1:0] STEADY_MAX  = 2'd3;
  localparam logic [1:0] STEADY_DONE = 2'd2;

  typedef enum logic [3:0] {
    PH_NONE  = 4'b0001,
    PH_START = 4'b0010,
    PH_IN    = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic signed [OFFSET_WIDTH-1:0] left_offset;
    logic [CONF_WIDTH-1:0]          left_confidence;
    logic signed [OFFSET_WIDTH-1:0] right_offset;
    logic [CONF_WIDTH-1:0]          right_confidence;
  } in_item_t;

  typedef struct packed {
    logic       left_change;
    logic       right_change;
    logic [1:0] phase_out;
  } out_item_t;

  typedef struct packed {
    logic [CONF_WIDTH-1:0] quality_threshold;
    logic [THR_WIDTH-1:0]  start_offset_limit;
    logic [THR_WIDTH-1:0]  jump_width;
    logic [THR_WIDTH-1:0]  settle_delta;
    logic [THR_WIDTH-1:0]  abort_offset;
  } cfg_regs_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] steady_count;
    logic       pending_left;
    logic       pending_right;
  } lcd_state_t;

  // previous frame offsets, confidences one and two frames back
  typedef struct packed {
    logic signed [OFFSET_WIDTH-1:0] left_offset_p;
    logic signed [OFFSET_WIDTH-1:0] right_offset_p;
    logic [CONF_WIDTH-1:0]          left_conf_p;
    logic [CONF_WIDTH-1:0]          right_conf_p;
    logic [CONF_WIDTH-1:0]          left_conf_pp;
    logic [CONF_WIDTH-1:0]          right_conf_pp;
  } lcd_hist_t;

  function automatic logic [MAG_WIDTH-1:0] mag_of(input logic [MAG_WIDTH-1:0] v);
    mag_of = v[MAG_WIDTH-1] ? (~v + MAG_WIDTH'(1)) : v;
  endfunction

  function automatic logic [MAG_WIDTH-1:0] sext_off(input logic [OFFSET_WIDTH-1:0] v);
    sext_off = {v[OFFSET_WIDTH-1], v};
  endfunction

  function automatic logic [1:0] phase_code(input phase_t ph);
    case (ph)
      PH_NONE:  phase_code = PHASE_CODE_NONE;
      PH_START: phase_code = PHASE_CODE_START;
      PH_IN:    phase_code = PHASE_CODE_IN;
      PH_END:   phase_code = PHASE_CODE_END;
      default:  phase_code = PHASE_CODE_NONE;
    endcase
  endfunction

endpackage

>>> rtl/core/lcd_step.sv
// ----------------------------------------------------------------------------
// lcd_step
// per-frame decision logic: quality, magnitudes, jumps and phase update
// ----------------------------------------------------------------------------
module lcd_step (
  input  lcd_pkg::in_item_t   item,
  input  lcd_pkg::cfg_regs_t  cfg,
  input  lcd_pkg::lcd_state_t state,
  input  lcd_pkg::lcd_hist_t  hist,
  output lcd_pkg::lcd_state_t state_nxt,
  output lcd_pkg::lcd_hist_t  hist_nxt,
  output lcd_pkg::out_item_t  result_nxt
);

  logic [lcd_pkg::MAG_WIDTH-1:0] lo_ext, ro_ext;
  logic [lcd_pkg::MAG_WIDTH-1:0] lmag_w, rmag_w, ldelta_w, rdelta_w;
  logic [lcd_pkg::CMP_WIDTH-1:0] lmag, rmag, ldelta, rdelta;
  logic [lcd_pkg::CMP_WIDTH-1:0] start_lim, jump_w, settle_d, abort_o;
  logic quality, start, jump, steady, abort_hit;
  logic [1:0] steady_inc;
  logic flag_en;

  always_comb begin
    lo_ext   = lcd_pkg::sext_off(item.left_offset);
    ro_ext   = lcd_pkg::sext_off(item.right_offset);
    lmag_w   = lcd_pkg::mag_of(lo_ext);
    rmag_w   = lcd_pkg::mag_of(ro_ext);
    ldelta_w = lcd_pkg::mag_of(lo_ext - lcd_pkg::sext_off(hist.left_offset_p));
    rdelta_w = lcd_pkg::mag_of(ro_ext - lcd_pkg::sext_off(hist.right_offset_p));
    lmag     = lcd_pkg::CMP_WIDTH'(lmag_w);
    rmag     = lcd_pkg::CMP_WIDTH'(rmag_w);
    ldelta   = lcd_pkg::CMP_WIDTH'(ldelta_w);
    rdelta   = lcd_pkg::CMP_WIDTH'(rdelta_w);
    start_lim = lcd_pkg::CMP_WIDTH'(cfg.start_offset_limit);
    jump_w    = lcd_pkg::CMP_WIDTH'(cfg.jump_width);
    settle_d  = lcd_pkg::CMP_WIDTH'(cfg.settle_delta);
    abort_o   = lcd_pkg::CMP_WIDTH'(cfg.abort_offset);

    quality = (item.left_confidence > cfg.quality_threshold) &&
              (hist.left_conf_pp > cfg.quality_threshold) &&
              (item.right_confidence > cfg.quality_threshold) &&
              (hist.right_conf_pp > cfg.quality_threshold);
    start     = quality && ((lmag < start_lim) || (rmag < start_lim));
    jump      = (ldelta > jump_w) && (rdelta > jump_w);
    steady    = (ldelta < settle_d) && (rdelta < settle_d);
    abort_hit = (lmag > abort_o) && (rmag > abort_o);

    steady_inc = (state.steady_count < lcd_pkg::STEADY_MAX) ?
                 state.steady_count + 2'd1 : state.steady_count;

    state_nxt = state;
    flag_en   = 1'b0;
    case (state.phase)
      lcd_pkg::PH_NONE: begin
        state_nxt.steady_count = 2'd0;
        if (start) begin
          state_nxt.phase = lcd_pkg::PH_START;
        end
      end
      lcd_pkg::PH_START: begin
        if (!quality || abort_hit) begin
          state_nxt.phase = lcd_pkg::PH_NONE;
        end else if (jump) begin
          state_nxt.phase = lcd_pkg::PH_IN;
          flag_en = 1'b1;
        end
      end
      lcd_pkg::PH_IN: begin
        if (!quality) begin
          state_nxt.phase = lcd_pkg::PH_NONE;
        end else begin
          state_nxt.steady_count = steady ? steady_inc : 2'd0;
          if (state_nxt.steady_count > lcd_pkg::STEADY_DONE) begin
            state_nxt.phase = lcd_pkg::PH_END;
          end else begin
            flag_en = 1'b1;
          end
        end
      end
      default: begin
        state_nxt.steady_count = 2'd0;
        state_nxt.phase = lcd_pkg::PH_NONE;
      end
    endcase

    // direction latches while starting, clears once idle or settled
    if (state_nxt.phase == lcd_pkg::PH_START) begin
      if (lmag > rmag) begin
        state_nxt.pending_right = 1'b1;
      end else begin
        state_nxt.pending_left = 1'b1;
      end
    end else if (state_nxt.phase == lcd_pkg::PH_END ||
                 state_nxt.phase == lcd_pkg::PH_NONE) begin
      state_nxt.pending_left  = 1'b0;
      state_nxt.pending_right = 1'b0;
    end

    result_nxt.left_change  = flag_en && state.pending_left;
    result_nxt.right_change = flag_en && state.pending_right;
    result_nxt.phase_out    = lcd_pkg::phase_code(state_nxt.phase);

    hist_nxt.left_offset_p  = item.left_offset;
    hist_nxt.right_offset_p = item.right_offset;
    hist_nxt.left_conf_p    = item.left_confidence;
    hist_nxt.right_conf_p   = item.right_confidence;
    hist_nxt.left_conf_pp   = hist.left_conf_p;
    hist_nxt.right_conf_pp  = hist.right_conf_p;
  end

endmodule

>>> rtl/core/lane_change_detector.sv
// ----------------------------------------------------------------------------
// lane_change_detector
// tracks lane-line offsets over frames and flags left or right lane changes
// ----------------------------------------------------------------------------
//  channel | ports                                  | carries
//  in      | in_valid, in_ready, in_item            | one perception frame
//  out     | out_valid, out_ready, out_item         | change flags and phase
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | threshold writes
//
//  one frame per cycle sustained unless out_ready stalls; a request lands
//  in the input register, then the decision logic fills the result
//  register from it and raises the out request
//  reset is synchronous: phase none, history zero, thresholds at defaults
//  a stalled result holds both stages; each stage refills as it drains
//  cfg writes always ready, setting one threshold each
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lane_change_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lcd_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lcd_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcd_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [lcd_pkg::THR_WIDTH-1:0]       cfg_data
);

  logic                s1_valid_r;
  lcd_pkg::in_item_t   in_item_r;
  logic                out_valid_r;
  lcd_pkg::out_item_t  out_item_r;
  lcd_pkg::cfg_regs_t  cfg_r;
  lcd_pkg::lcd_state_t state_r, state_nxt;
  lcd_pkg::lcd_hist_t  hist_r, hist_nxt;
  lcd_pkg::out_item_t  result_nxt;
  logic                advance;
  logic                step_fire;

  assign advance   = !out_valid_r || out_ready;
  assign step_fire = advance && s1_valid_r;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  lcd_step u_step (
    .item       (in_item_r),
    .cfg        (cfg_r),
    .state      (state_r),
    .hist       (hist_r),
    .state_nxt  (state_nxt),
    .hist_nxt   (hist_nxt),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (step_fire) begin
      out_item_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= lcd_pkg::PH_NONE;
      state_r.steady_count  <= 2'd0;
      state_r.pending_left  <= 1'b0;
      state_r.pending_right <= 1'b0;
      hist_r                <= '0;
    end else if (step_fire) begin
      state_r <= state_nxt;
      hist_r  <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quality_threshold  <= lcd_pkg::RST_QUALITY_THRESHOLD;
      cfg_r.start_offset_limit <= lcd_pkg::RST_START_OFFSET_LIMIT;
      cfg_r.jump_width         <= lcd_pkg::RST_JUMP_WIDTH;
      cfg_r.settle_delta       <= lcd_pkg::RST_SETTLE_DELTA;
      cfg_r.abort_offset       <= lcd_pkg::RST_ABORT_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcd_pkg::CFG_QUALITY_THRESHOLD:
          cfg_r.quality_threshold <= cfg_data[lcd_pkg::CONF_WIDTH-1:0];
        lcd_pkg::CFG_START_OFFSET_LIMIT: cfg_r.start_offset_limit <= cfg_data;
        lcd_pkg::CFG_JUMP_WIDTH:         cfg_r.jump_width         <= cfg_data;
        lcd_pkg::CFG_SETTLE_DELTA:       cfg_r.settle_delta       <= cfg_data;
        lcd_pkg::CFG_ABORT_OFFSET:       cfg_r.abort_offset       <= cfg_data;
        default: ;
      endcase
    end
  end

  `ASSERT_IMPLY(a_flags_only_in, clk, rst_n,
    out_valid_r && (out_item_r.left_change || out_item_r.right_change),
    out_item_r.phase_out == lcd_pkg::PHASE_CODE_IN)
  `ASSERT_IMPLY(a_idle_no_pending, clk, rst_n,
    state_r.phase == lcd_pkg::PH_NONE,
    !state_r.pending_left && !state_r.pending_right)
  `ASSERT_IMPLY(a_full_count_ends, clk, rst_n,
    state_r.steady_count == lcd_pkg::STEADY_MAX,
    state_r.phase == lcd_pkg::PH_END)
  `ASSERT_NEXT(a_step_gives_result, clk, rst_n,
    step_fire,
    out_valid_r && out_item_r.phase_out == lcd_pkg::phase_code(state_r.phase))

endmodule
